/* sv/gda_pkg.sv */
// shared widths, calendar constants, month table and arithmetic unit types for date arithmetic
`timescale 1ns / 1ps

package gda_pkg;

   // field widths
   localparam int DayW     = 6;
   localparam int MonW     = 4;
   localparam int YearW    = 14;
   localparam int OffW     = 23;
   localparam int MonLenW  = 5;

   // accumulator holds serial day numbers plus or minus an offset
   localparam int AccW     = 25;

   // default upper year limit for add results
   localparam int MaxYearDefault = 9999;

   // action codes
   localparam logic ActAdd  = 1'b0;
   localparam logic ActDiff = 1'b1;

   // days in whole blocks of years
   localparam logic signed [AccW-1:0] Days400 = AccW'(146097);
   localparam logic signed [AccW-1:0] Days100 = AccW'(36524);
   localparam logic signed [AccW-1:0] Days4   = AccW'(1461);
   localparam logic signed [AccW-1:0] Days1   = AccW'(365);

   // year counts of those blocks
   localparam logic [YearW-1:0] Years400 = YearW'(400);
   localparam logic [YearW-1:0] Years100 = YearW'(100);
   localparam logic [YearW-1:0] Years4   = YearW'(4);
   localparam logic [YearW-1:0] Years1   = YearW'(1);

   localparam logic [MonW-1:0] MonthLast = MonW'(12);

   // operands for the shared arithmetic unit
   typedef struct packed {
      logic signed [AccW-1:0] a;
      logic signed [AccW-1:0] b;
      logic [YearW-1:0]       ctr;
      logic [YearW-1:0]       step;
      logic                   ctr_sub;
   } alu_in_type;

   // results of the shared arithmetic unit
   typedef struct packed {
      logic signed [AccW-1:0] sum;
      logic                   neg;
      logic [YearW-1:0]       ctr_sum;
      logic                   ctr_ge;
   } alu_out_type;

   // days in a month, zero for a month code outside 1..12
   function automatic logic [MonLenW-1:0] month_len(input logic leap, input logic [MonW-1:0] m);
      logic [MonLenW-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = MonLenW'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = MonLenW'(30);
         4'd2:                                       len = leap ? MonLenW'(29) : MonLenW'(28);
         default:                                    len = '0;
      endcase
      return len;
   endfunction

endpackage

/* sv/gregorian_date_arithmetic.sv */
// gregorian date add and difference with a sequenced shared arithmetic unit
//
//   channel | direction | handshake              | contents
//   req     | in        | req_valid / req_ready  | action, two dates, day offset
//   rsp     | out       | rsp_valid / rsp_ready  | shifted date, day count, flags
//
// a transaction runs from acceptance to the output register through the year
// decomposition loops (400-year blocks dominate, then 4-year blocks), run once
// per input date and once more for an add result, each through the one adder;
// a date that fails the plain range checks skips its loops.
// req_ready is high only while the sequencer is idle; a finished result moves to
// the output register when it is free or being drained, else the sequencer waits.
// reset is synchronous and clears the sequencer and rsp_valid.
`timescale 1ns / 1ps

module gregorian_date_arithmetic import gda_pkg::*; #(
   parameter int MAX_YEAR = MaxYearDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [DayW-1:0]        req_first_day,
   input  logic [MonW-1:0]        req_first_month,
   input  logic [YearW-1:0]       req_first_year,
   input  logic [DayW-1:0]        req_second_day,
   input  logic [MonW-1:0]        req_second_month,
   input  logic [YearW-1:0]       req_second_year,
   input  logic signed [OffW-1:0] req_day_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DayW-1:0]        rsp_result_day,
   output logic [MonW-1:0]        rsp_result_month,
   output logic [YearW-1:0]       rsp_result_year,
   output logic                   rsp_result_valid,
   output logic signed [OffW-1:0] rsp_day_count,
   output logic                   rsp_first_valid,
   output logic                   rsp_second_valid,
   output logic                   rsp_first_less,
   output logic                   rsp_dates_equal
);

   // serial number of 31-12-MAX_YEAR
   localparam int LastSerialInt =
      MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 - 1;
   localparam logic signed [AccW-1:0] LastSerial = AccW'(LastSerialInt);
   localparam logic signed [AccW-1:0] SatHi = AccW'(2 ** (OffW - 1) - 1);
   localparam logic signed [AccW-1:0] SatLo = -AccW'(2 ** (OffW - 1));

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_Y400, S_Y100, S_Y4, S_Y1, S_CHECK, S_MON, S_FIN,
      S_ACT, S_RANGE, S_D400, S_D100, S_D4, S_D1, S_DMON, S_DONE
   } state_type;

   state_type              state_ff;
   logic                   sel_ff;
   logic                   action_ff;
   logic [DayW-1:0]        fd_ff, sd_ff;
   logic [MonW-1:0]        fm_ff, sm_ff;
   logic [YearW-1:0]       fy_ff, sy_ff;
   logic signed [OffW-1:0] off_ff;
   logic signed [AccW-1:0] acc_ff;
   logic signed [AccW-1:0] ser_a_ff;
   logic [YearW-1:0]       ctr_ff;
   logic [MonW-1:0]        mon_ff;
   logic [1:0]             n1_ff;
   logic [1:0]             n100_ff;
   logic [4:0]             n4_ff;
   logic                   f400_ff, f100_ff, leap_ff;
   logic                   fv_ff, sv_ff, rv_ff;
   logic [DayW-1:0]        res_day_ff;
   logic [MonW-1:0]        res_month_ff;
   logic [YearW-1:0]       res_year_ff;

   logic                   rsp_valid_ff;
   logic [DayW-1:0]        rsp_result_day_ff;
   logic [MonW-1:0]        rsp_result_month_ff;
   logic [YearW-1:0]       rsp_result_year_ff;
   logic                   rsp_result_valid_ff;
   logic signed [OffW-1:0] rsp_day_count_ff;
   logic                   rsp_first_valid_ff;
   logic                   rsp_second_valid_ff;
   logic                   rsp_first_less_ff;
   logic                   rsp_dates_equal_ff;

   alu_in_type             alu_in;
   alu_out_type            alu_out;

   logic [DayW-1:0]        cur_d;
   logic [MonW-1:0]        cur_m;
   logic [YearW-1:0]       cur_y;
   logic                   range_ok;
   logic                   day_fits;
   logic [MonLenW-1:0]     mon_len;
   logic                   date_done;
   logic signed [AccW-1:0] count_sat;

   gda_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   // date under evaluation and its plain range checks
   always_comb begin
      cur_d    = sel_ff ? sd_ff : fd_ff;
      cur_m    = sel_ff ? sm_ff : fm_ff;
      cur_y    = sel_ff ? sy_ff : fy_ff;
      range_ok = (cur_d != '0) && (cur_d <= DayW'(31)) && (cur_m != '0)
                 && (cur_m <= MonthLast) && (cur_y != '0);
      day_fits = (cur_d <= {1'b0, month_len(leap_ff, cur_m)});
      mon_len  = month_len(leap_ff, mon_ff);
      date_done = ((state_ff == S_START) && !range_ok)
                  || ((state_ff == S_CHECK) && !day_fits)
                  || (state_ff == S_FIN);
   end

   // operand selection for the shared unit
   always_comb begin
      alu_in.a       = acc_ff;
      alu_in.b       = '0;
      alu_in.ctr     = ctr_ff;
      alu_in.step    = Years1;
      alu_in.ctr_sub = 1'b0;
      case (state_ff)
         S_Y400: begin
            alu_in.b = Days400; alu_in.step = Years400; alu_in.ctr_sub = 1'b1;
         end
         S_Y100: begin
            alu_in.b = Days100; alu_in.step = Years100; alu_in.ctr_sub = 1'b1;
         end
         S_Y4: begin
            alu_in.b = Days4; alu_in.step = Years4; alu_in.ctr_sub = 1'b1;
         end
         S_Y1: begin
            alu_in.b = Days1; alu_in.step = Years1; alu_in.ctr_sub = 1'b1;
         end
         S_MON: alu_in.b = {{(AccW-MonLenW){1'b0}}, mon_len};
         S_FIN: alu_in.b = {{(AccW-DayW){1'b0}}, cur_d} - AccW'(1);
         S_ACT: begin
            if (action_ff == ActDiff) begin
               alu_in.b = -ser_a_ff;
            end else begin
               alu_in.a = ser_a_ff;
               alu_in.b = {{(AccW-OffW){off_ff[OffW-1]}}, off_ff};
            end
         end
         S_D400: begin
            alu_in.b = -Days400; alu_in.step = Years400;
         end
         S_D100: begin
            alu_in.b = -Days100; alu_in.step = Years100;
         end
         S_D4: begin
            alu_in.b = -Days4; alu_in.step = Years4;
         end
         S_D1: begin
            alu_in.b = -Days1; alu_in.step = Years1;
         end
         S_DMON: alu_in.b = -{{(AccW-MonLenW){1'b0}}, mon_len};
         default: alu_in.b = '0;
      endcase
   end

   // day count clamped to the output range
   always_comb begin
      if (acc_ff > SatHi) begin
         count_sat = SatHi;
      end else if (acc_ff < SatLo) begin
         count_sat = SatLo;
      end else begin
         count_sat = acc_ff;
      end
   end

   // sequencer, working registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  action_ff <= req_action;
                  fd_ff     <= req_first_day;
                  fm_ff     <= req_first_month;
                  fy_ff     <= req_first_year;
                  sd_ff     <= req_second_day;
                  sm_ff     <= req_second_month;
                  sy_ff     <= req_second_year;
                  off_ff    <= req_day_offset;
                  sel_ff    <= 1'b0;
                  rv_ff     <= 1'b0;
                  state_ff  <= S_START;
               end
            end
            S_START: begin
               if (range_ok) begin
                  ctr_ff   <= cur_y - YearW'(1);
                  acc_ff   <= '0;
                  state_ff <= S_Y400;
               end
            end
            // split year-1 into 400, 100, 4 and 1 year blocks
            S_Y400: begin
               if (alu_out.ctr_ge) begin
                  ctr_ff <= alu_out.ctr_sum;
                  acc_ff <= alu_out.sum;
               end else begin
                  f400_ff  <= (ctr_ff == YearW'(399));
                  state_ff <= S_Y100;
               end
            end
            S_Y100: begin
               if (alu_out.ctr_ge) begin
                  ctr_ff <= alu_out.ctr_sum;
                  acc_ff <= alu_out.sum;
               end else begin
                  f100_ff  <= (ctr_ff == YearW'(99));
                  state_ff <= S_Y4;
               end
            end
            S_Y4: begin
               if (alu_out.ctr_ge) begin
                  ctr_ff <= alu_out.ctr_sum;
                  acc_ff <= alu_out.sum;
               end else begin
                  leap_ff  <= (ctr_ff == YearW'(3)) && (!f100_ff || f400_ff);
                  state_ff <= S_Y1;
               end
            end
            S_Y1: begin
               if (alu_out.ctr_ge) begin
                  ctr_ff <= alu_out.ctr_sum;
                  acc_ff <= alu_out.sum;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (day_fits) begin
                  mon_ff   <= MonW'(1);
                  state_ff <= S_MON;
               end
            end
            // add whole months before the current one
            S_MON: begin
               if (mon_ff < cur_m) begin
                  acc_ff <= alu_out.sum;
                  mon_ff <= mon_ff + MonW'(1);
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               acc_ff <= alu_out.sum;
            end
            S_ACT: begin
               if (action_ff == ActDiff) begin
                  if (fv_ff && sv_ff) begin
                     acc_ff <= alu_out.sum;
                  end
                  state_ff <= S_DONE;
               end else if (fv_ff) begin
                  acc_ff   <= alu_out.sum;
                  state_ff <= S_RANGE;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_RANGE: begin
               if (!acc_ff[AccW-1] && (acc_ff <= LastSerial)) begin
                  ctr_ff   <= '0;
                  n100_ff  <= '0;
                  n4_ff    <= '0;
                  n1_ff    <= '0;
                  state_ff <= S_D400;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            // peel blocks of days off the serial number, building year-1
            S_D400: begin
               if (!alu_out.neg) begin
                  acc_ff <= alu_out.sum;
                  ctr_ff <= alu_out.ctr_sum;
               end else begin
                  state_ff <= S_D100;
               end
            end
            S_D100: begin
               if ((n100_ff != 2'd3) && !alu_out.neg) begin
                  acc_ff  <= alu_out.sum;
                  ctr_ff  <= alu_out.ctr_sum;
                  n100_ff <= n100_ff + 2'd1;
               end else begin
                  state_ff <= S_D4;
               end
            end
            S_D4: begin
               if (!alu_out.neg) begin
                  acc_ff <= alu_out.sum;
                  ctr_ff <= alu_out.ctr_sum;
                  n4_ff  <= n4_ff + 5'd1;
               end else begin
                  state_ff <= S_D1;
               end
            end
            S_D1: begin
               if ((n1_ff != 2'd3) && !alu_out.neg) begin
                  acc_ff <= alu_out.sum;
                  ctr_ff <= alu_out.ctr_sum;
                  n1_ff  <= n1_ff + 2'd1;
               end else begin
                  leap_ff  <= (n1_ff == 2'd3) && ((n4_ff != 5'd24) || (n100_ff == 2'd3));
                  mon_ff   <= MonW'(1);
                  state_ff <= S_DMON;
               end
            end
            S_DMON: begin
               if ((mon_ff < MonthLast) && !alu_out.neg) begin
                  acc_ff <= alu_out.sum;
                  mon_ff <= mon_ff + MonW'(1);
               end else begin
                  res_day_ff   <= acc_ff[DayW-1:0] + DayW'(1);
                  res_month_ff <= mon_ff;
                  res_year_ff  <= ctr_ff + YearW'(1);
                  rv_ff        <= 1'b1;
                  state_ff     <= S_DONE;
               end
            end
            // hand the transaction to the output register once it is free or being drained
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_result_day_ff   <= rv_ff ? res_day_ff : fd_ff;
                  rsp_result_month_ff <= rv_ff ? res_month_ff : fm_ff;
                  rsp_result_year_ff  <= rv_ff ? res_year_ff : fy_ff;
                  rsp_result_valid_ff <= rv_ff;
                  rsp_day_count_ff    <= ((action_ff == ActDiff) && fv_ff && sv_ff) ?
                                         count_sat[OffW-1:0] : '0;
                  rsp_first_valid_ff  <= fv_ff;
                  rsp_second_valid_ff <= sv_ff;
                  rsp_first_less_ff   <= fv_ff && sv_ff &&
                                         ({fy_ff, fm_ff, fd_ff} < {sy_ff, sm_ff, sd_ff});
                  rsp_dates_equal_ff  <= (!fv_ff && !sv_ff) ||
                                         ({fy_ff, fm_ff, fd_ff} == {sy_ff, sm_ff, sd_ff});
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // a date is finished: keep the first, move on after the second
         if (date_done) begin
            if (sel_ff) begin
               sv_ff    <= (state_ff == S_FIN);
               state_ff <= S_ACT;
            end else begin
               fv_ff    <= (state_ff == S_FIN);
               ser_a_ff <= alu_out.sum;
               sel_ff   <= 1'b1;
               state_ff <= S_START;
            end
         end
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_day   = rsp_result_day_ff;
   assign rsp_result_month = rsp_result_month_ff;
   assign rsp_result_year  = rsp_result_year_ff;
   assign rsp_result_valid = rsp_result_valid_ff;
   assign rsp_day_count    = rsp_day_count_ff;
   assign rsp_first_valid  = rsp_first_valid_ff;
   assign rsp_second_valid = rsp_second_valid_ff;
   assign rsp_first_less   = rsp_first_less_ff;
   assign rsp_dates_equal  = rsp_dates_equal_ff;

`ifndef SYNTHESIS
   // a shifted date only comes from a valid first date
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_valid) |-> rsp_first_valid)
      else $error("result valid without a valid first date");

   // a shifted date stays inside the supported years
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_valid) |->
         ((rsp_result_year != '0) && (rsp_result_year <= YearW'(MAX_YEAR))))
      else $error("shifted year out of range");

   // a nonzero day count needs both dates valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_day_count != '0)) |-> (rsp_first_valid && rsp_second_valid))
      else $error("day count from an invalid date");

   // earlier and equal exclude each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_first_less && rsp_dates_equal))
      else $error("first_less and dates_equal both set");

   // the sequencer is busy right after taking a transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accepting a transaction");
`endif

endmodule

/* sv/gda_alu.sv */
// shared accumulator adder and year counter used by the arithmetic sequencer steps
`timescale 1ns / 1ps

module gda_alu import gda_pkg::*; (
   input  alu_in_type  alu_in,
   output alu_out_type alu_out
);

   // accumulator add, sign doubles as the compare result for subtract steps
   always_comb begin
      alu_out.sum     = alu_in.a + alu_in.b;
      alu_out.neg     = alu_out.sum[AccW-1];
      alu_out.ctr_sum = alu_in.ctr_sub ? (alu_in.ctr - alu_in.step) : (alu_in.ctr + alu_in.step);
      alu_out.ctr_ge  = (alu_in.ctr >= alu_in.step);
   end

endmodule

/* test/gregorian_date_arithmetic_test.sv */
// self-checking testbench for the gregorian date add and difference block
`timescale 1ns / 1ps

module gregorian_date_arithmetic_test;
   import gda_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 10;
   localparam int MAX_YEAR_LIMIT = MaxYearDefault;
   localparam int SETTLE_CYCLES = 600;
   localparam int HOLD_CYCLES = 1500;
   localparam int REPORT_CAP = 60;

   typedef struct {
      logic                   action;
      logic [DayW-1:0]        first_day;
      logic [MonW-1:0]        first_month;
      logic [YearW-1:0]       first_year;
      logic [DayW-1:0]        second_day;
      logic [MonW-1:0]        second_month;
      logic [YearW-1:0]       second_year;
      logic signed [OffW-1:0] day_offset;
   } date_request_type;

   typedef struct {
      logic [DayW-1:0]        day;
      logic [MonW-1:0]        month;
      logic [YearW-1:0]       year;
      logic                   shifted_ok;
      logic signed [OffW-1:0] day_count;
      logic                   first_ok;
      logic                   second_ok;
      logic                   first_less;
      logic                   dates_equal;
   } date_result_type;

   // calendar predictor and in-order result checker
   class date_scoreboard;
      date_result_type expected_results[$];
      int errors;
      longint max_year;

      function new(longint max_year_arg);
         max_year = max_year_arg;
         errors = 0;
      endfunction

      static function bit is_leap(longint y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      static function longint month_days(bit leap, longint m);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      static function bit date_valid(longint d, longint m, longint y);
         if (d < 1 || d > 31) return 1'b0;
         if (m < 1 || m > 12) return 1'b0;
         if (y < 1) return 1'b0;
         return d <= month_days(is_leap(y), m);
      endfunction

      // days from 1-1-1 to 1-1 of year y
      static function longint year_start(longint y);
         longint p;
         p = y - 1;
         return p * 365 + p / 4 - p / 100 + p / 400;
      endfunction

      // day number of a valid date, 1-1-1 is day 0
      static function longint day_number(longint d, longint m, longint y);
         longint total;
         bit leap;
         total = year_start(y);
         leap = is_leap(y);
         for (longint k = 1; k < m && k <= 12; k++) total += month_days(leap, k);
         return total + d - 1;
      endfunction

      static function void calendar_date(longint s, output longint d, output longint m,
                                         output longint y);
         longint yy;
         longint mm;
         bit leap;
         yy = (s * 400) / 146097 + 1;
         if (yy < 1) yy = 1;
         while (year_start(yy + 1) <= s) yy++;
         while (yy > 1 && year_start(yy) > s) yy--;
         s -= year_start(yy);
         leap = is_leap(yy);
         mm = 1;
         while (mm < 12 && s >= month_days(leap, mm)) begin
            s -= month_days(leap, mm);
            mm++;
         end
         d = s + 1;
         m = mm;
         y = yy;
      endfunction

      function date_result_type compute_result(date_request_type r);
         date_result_type res;
         longint fd, fm, fy, sd, sm, sy, off, shifted, top, count, nd, nm, ny;
         bit fv, sv;
         fd = r.first_day;
         fm = r.first_month;
         fy = r.first_year;
         sd = r.second_day;
         sm = r.second_month;
         sy = r.second_year;
         off = longint'(r.day_offset);
         fv = date_valid(fd, fm, fy);
         sv = date_valid(sd, sm, sy);
         res.day = r.first_day;
         res.month = r.first_month;
         res.year = r.first_year;
         res.shifted_ok = 1'b0;
         res.first_ok = fv;
         res.second_ok = sv;
         res.first_less = 1'b0;
         count = 0;
         // ordering by year, then month, then day
         if (fv && sv) begin
            if (fy != sy) res.first_less = fy < sy;
            else if (fm != sm) res.first_less = fm < sm;
            else res.first_less = fd < sd;
         end
         res.dates_equal = (!fv && !sv) || (fd == sd && fm == sm && fy == sy);
         if (r.action == ActAdd) begin
            if (fv) begin
               shifted = day_number(fd, fm, fy) + off;
               top = day_number(31, 12, max_year);
               if (shifted >= 0 && shifted <= top) begin
                  calendar_date(shifted, nd, nm, ny);
                  res.day = DayW'(nd);
                  res.month = MonW'(nm);
                  res.year = YearW'(ny);
                  res.shifted_ok = 1'b1;
               end
            end
         end else if (fv && sv) begin
            // signed distance, saturated to the count width
            count = day_number(sd, sm, sy) - day_number(fd, fm, fy);
            if (count > 4194303) count = 4194303;
            if (count < -4194304) count = -4194304;
         end
         res.day_count = count[OffW-1:0];
         return res;
      endfunction

      function void note_request(date_request_type r);
         expected_results.push_back(compute_result(r));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void compare_field(string field, longint want, longint got);
         if (want != got) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(date_result_type got);
         date_result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: result expected none actual day %0d month %0d year %0d",
                        $time, got.day, got.month, got.year);
            return;
         end
         want = expected_results.pop_front();
         compare_field("result_day", want.day, got.day);
         compare_field("result_month", want.month, got.month);
         compare_field("result_year", want.year, got.year);
         compare_field("result_valid", want.shifted_ok, got.shifted_ok);
         compare_field("day_count", longint'(want.day_count), longint'(got.day_count));
         compare_field("first_valid", want.first_ok, got.first_ok);
         compare_field("second_valid", want.second_ok, got.second_ok);
         compare_field("first_less", want.first_less, got.first_less);
         compare_field("dates_equal", want.dates_equal, got.dates_equal);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_action = ActAdd;
   logic [DayW-1:0]        req_first_day = '0;
   logic [MonW-1:0]        req_first_month = '0;
   logic [YearW-1:0]       req_first_year = '0;
   logic [DayW-1:0]        req_second_day = '0;
   logic [MonW-1:0]        req_second_month = '0;
   logic [YearW-1:0]       req_second_year = '0;
   logic signed [OffW-1:0] req_day_offset = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [DayW-1:0]        rsp_result_day;
   logic [MonW-1:0]        rsp_result_month;
   logic [YearW-1:0]       rsp_result_year;
   logic                   rsp_result_valid;
   logic signed [OffW-1:0] rsp_day_count;
   logic                   rsp_first_valid;
   logic                   rsp_second_valid;
   logic                   rsp_first_less;
   logic                   rsp_dates_equal;

   int rsp_stall_pct = 0;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_left = 0;

   date_scoreboard sb;

   gregorian_date_arithmetic #(.MAX_YEAR(MAX_YEAR_LIMIT)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_first_day   (req_first_day),
      .req_first_month (req_first_month),
      .req_first_year  (req_first_year),
      .req_second_day  (req_second_day),
      .req_second_month(req_second_month),
      .req_second_year (req_second_year),
      .req_day_offset  (req_day_offset),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_day  (rsp_result_day),
      .rsp_result_month(rsp_result_month),
      .rsp_result_year (rsp_result_year),
      .rsp_result_valid(rsp_result_valid),
      .rsp_day_count   (rsp_day_count),
      .rsp_first_valid (rsp_first_valid),
      .rsp_second_valid(rsp_second_valid),
      .rsp_first_less  (rsp_first_less),
      .rsp_dates_equal (rsp_dates_equal)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // result side: check each transaction, random stalls, long hold-off on request
   always @(posedge clock) begin : response_side
      date_result_type seen;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.day = rsp_result_day;
            seen.month = rsp_result_month;
            seen.year = rsp_result_year;
            seen.shifted_ok = rsp_result_valid;
            seen.day_count = rsp_day_count;
            seen.first_ok = rsp_first_valid;
            seen.second_ok = rsp_second_valid;
            seen.first_less = rsp_first_less;
            seen.dates_equal = rsp_dates_equal;
            sb.check_result(seen);
         end
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic date_request_type make_req(logic act, int fd, int fm, int fy,
                                                 int sd, int sm, int sy, int off);
      date_request_type r;
      r.action = act;
      r.first_day = DayW'(fd);
      r.first_month = MonW'(fm);
      r.first_year = YearW'(fy);
      r.second_day = DayW'(sd);
      r.second_month = MonW'(sm);
      r.second_year = YearW'(sy);
      r.day_offset = OffW'(off);
      return r;
   endfunction

   // mostly well-formed dates, some near the month end, some raw noise
   function automatic void pick_date(output logic [DayW-1:0] d, output logic [MonW-1:0] m,
                                     output logic [YearW-1:0] y);
      int notable_years[10] = '{1, 2, 4, 100, 400, 1600, 1900, 2000, 2100, 9999};
      int unsigned kind;
      longint yy;
      longint mm;
      kind = $urandom_range(99);
      case ($urandom_range(9))
         0:       yy = notable_years[$urandom_range(9)];
         1:       yy = $urandom_range(16383, 10000);
         default: yy = $urandom_range(9999, 1);
      endcase
      mm = $urandom_range(12, 1);
      if (kind < 75) begin
         d = DayW'($urandom_range(date_scoreboard::month_days(date_scoreboard::is_leap(yy),
                                                             mm), 1));
      end else if (kind < 90) begin
         d = DayW'($urandom_range(31, 28));
         if ($urandom_range(5) == 0) yy = 0;
         if ($urandom_range(5) == 0) mm = $urandom_range(15, 13);
      end else begin
         d = DayW'($urandom);
         mm = $urandom_range(15);
         yy = $urandom_range(16383);
      end
      m = MonW'(mm);
      y = YearW'(yy);
   endfunction

   function automatic date_request_type random_request();
      date_request_type r;
      int off;
      r.action = ($urandom_range(1) == 0) ? ActAdd : ActDiff;
      pick_date(r.first_day, r.first_month, r.first_year);
      if ($urandom_range(4) == 0) begin
         r.second_day = r.first_day;
         r.second_month = r.first_month;
         r.second_year = r.first_year;
      end else begin
         pick_date(r.second_day, r.second_month, r.second_year);
      end
      case ($urandom_range(9))
         0, 1, 2, 3: off = int'($urandom_range(800)) - 400;
         4, 5:       off = int'($urandom_range(80000)) - 40000;
         6, 7:       off = int'($urandom_range(7304118)) - 3652059;
         default:    off = int'($urandom);
      endcase
      r.day_offset = OffW'(off);
      return r;
   endfunction

   // offer one transaction after optional idle cycles, called at a rising edge
   task automatic send_request(input date_request_type r, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= r.action;
      req_first_day <= r.first_day;
      req_first_month <= r.first_month;
      req_first_year <= r.first_year;
      req_second_day <= r.second_day;
      req_second_month <= r.second_month;
      req_second_year <= r.second_year;
      req_day_offset <= r.day_offset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      rsp_stall_pct <= stall_pct;
      for (int i = 0; i < count; i++) send_request(random_request(), idle_pct);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   initial begin
      #(CLOCK_PERIOD * 500_000);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      sb = new(MAX_YEAR_LIMIT);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // range edges, leap rules, invalid dates, saturation
      send_request(make_req(ActAdd, 1, 1, 1, 1, 1, 1, 0), 0);
      send_request(make_req(ActAdd, 1, 1, 1, 2, 1, 1, -1), 0);
      send_request(make_req(ActAdd, 31, 12, 9999, 31, 12, 9999, 1), 0);
      send_request(make_req(ActAdd, 31, 12, 9999, 1, 1, 1, 0), 0);
      send_request(make_req(ActAdd, 28, 2, 2000, 1, 3, 2000, 1), 0);
      send_request(make_req(ActAdd, 28, 2, 1900, 28, 2, 1900, 1), 0);
      send_request(make_req(ActAdd, 1, 3, 2004, 1, 1, 2004, -1), 0);
      send_request(make_req(ActAdd, 29, 2, 1900, 1, 3, 1900, 5), 0);
      send_request(make_req(ActAdd, 0, 0, 0, 0, 0, 0, 0), 0);
      send_request(make_req(ActAdd, 63, 15, 16383, 63, 15, 16383, 4194303), 0);
      send_request(make_req(ActAdd, 15, 6, 5000, 1, 1, 1, -4194304), 0);
      send_request(make_req(ActAdd, 1, 1, 1, 31, 12, 9999, 3652058), 0);
      send_request(make_req(ActAdd, 1, 1, 12000, 1, 1, 1, 0), 0);
      send_request(make_req(ActAdd, 1, 1, 12000, 1, 1, 1, -1000000), 0);
      send_request(make_req(ActDiff, 1, 1, 1, 31, 12, 16383, 0), 0);
      send_request(make_req(ActDiff, 31, 12, 16383, 1, 1, 1, 0), 0);
      send_request(make_req(ActDiff, 1, 1, 1, 31, 12, 9999, 0), 0);
      send_request(make_req(ActDiff, 14, 7, 1789, 14, 7, 1789, 77), 0);
      send_request(make_req(ActDiff, 31, 4, 2001, 0, 13, 0, 0), 0);
      send_request(make_req(ActDiff, 32, 1, 2001, 1, 1, 2001, 0), 0);
      send_request(make_req(ActDiff, 1, 1, 2001, 29, 2, 2100, 0), 0);
      send_request(make_req(ActDiff, 31, 12, 1999, 1, 1, 2000, 0), 0);
      send_request(make_req(ActDiff, 1, 3, 2000, 30, 2, 2000, 0), 0);
      send_request(make_req(ActDiff, 29, 2, 2400, 1, 1, 12000, 0), 0);

      // sender waits for every outstanding result before the random part
      wait_drained();

      run_random(22, 0, 0);
      run_random(22, 85, 0);
      run_random(22, 0, 85);
      run_random(22, 27, 27);

      // receiver holds off while the sender keeps offering back to back
      rsp_stall_pct <= 0;
      hold_ticket <= hold_ticket + 1;
      for (int i = 0; i < 10; i++) send_request(random_request(), 0);

      run_random(22, 0, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
sv/gda_pkg.sv
sv/gda_alu.sv
sv/gregorian_date_arithmetic.sv
test/gregorian_date_arithmetic_test.sv
